// ===== hdl/fsq_pkg.sv =====
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared widths, types and product tables for the p25519 field squaring unit.
// ----------------------------------------------------------------------------
package fsq_pkg;

  localparam int LIMB_N = 5;
  localparam int LIMB_W = 52;
  localparam int MASK_W = 51;
  localparam int HALF_W = 26;
  localparam int PROD_W = 104;
  localparam int COL_W  = 112;
  localparam int RED_W  = 61;
  localparam int PROD_N = 15;
  localparam int DATA_W = 264;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [RED_W-1:0]  red_t;
  typedef logic [MASK_W-1:0] low_t;
  typedef logic [2:0]        lidx_t;
  typedef logic [1:0]        scale_t;

  localparam scale_t SCALE_1  = 2'd0;
  localparam scale_t SCALE_2  = 2'd1;
  localparam scale_t SCALE_19 = 2'd2;
  localparam scale_t SCALE_38 = 2'd3;

  // Products are listed three per column, column 0 first.
  localparam lidx_t PROD_A [PROD_N] = '{
    3'd0, 3'd1, 3'd2,  3'd0, 3'd2, 3'd3,  3'd0, 3'd1, 3'd3,
    3'd0, 3'd1, 3'd4,  3'd0, 3'd1, 3'd2};
  localparam lidx_t PROD_B [PROD_N] = '{
    3'd0, 3'd4, 3'd3,  3'd1, 3'd4, 3'd3,  3'd2, 3'd1, 3'd4,
    3'd3, 3'd2, 3'd4,  3'd4, 3'd3, 3'd2};
  localparam scale_t PROD_SCALE [PROD_N] = '{
    SCALE_1, SCALE_38, SCALE_38,  SCALE_2, SCALE_38, SCALE_19,
    SCALE_2, SCALE_1,  SCALE_38,  SCALE_2, SCALE_2,  SCALE_19,
    SCALE_2, SCALE_2,  SCALE_1};

endpackage

// ===== hdl/field_square_p25519_unit.sv =====
// ----------------------------------------------------------------------------
// field_square_p25519_unit
// Squares an element of GF(2^255 - 19) held as five radix-2^51 limbs.
// ----------------------------------------------------------------------------
// Usage: an operand beat enters on the s_axis group, five 52-bit limbs packed
// limb 0 lowest in s_axis_tdata. The square, after two carry passes, leaves on
// the m_axis group in the same packing; every limb of it is below 2^52.
// From an accepted beat to m_axis_tvalid the stages are partial products,
// full products, column sums, first and second carry pass; each carries its
// own valid bit. Throughput is one beat per cycle while m_axis_tready is high.
// A synchronous reset empties the pipeline; m_axis_tvalid is low afterwards.
// When the receiver holds m_axis_tready low, the last stage keeps its beat and
// stages behind it go on filling any empty slots; s_axis_tready falls only
// once every stage holds a beat. s_axis_tready depends combinationally on
// m_axis_tready through the stage valid bits.
// ----------------------------------------------------------------------------
module field_square_p25519_unit import fsq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // in_limb0, in_limb1, .. in_limb4, pad
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata    // sq_limb0, sq_limb1, .. sq_limb4, pad
);

  localparam int STAGES = 5;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;
  limb_t             x    [LIMB_N];
  prod_t             prod [PROD_N];
  col_t              col  [LIMB_N];
  low_t              low1 [LIMB_N];
  red_t              cy1  [LIMB_N];
  red_t              r1   [LIMB_N];
  low_t              low2 [LIMB_N];
  red_t              cy2  [LIMB_N];
  red_t              r2   [LIMB_N];

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[STAGES-1];

  for (genvar k = 0; k < LIMB_N; k++) begin : g_unpack
    assign x[k] = s_axis_tdata[k*LIMB_W +: LIMB_W];
  end

  for (genvar i = 0; i < PROD_N; i++) begin : g_mul
    fsq_mul52 u_mul (
      .clk     (clk),
      .en_pp   (adv[0]),
      .en_prod (adv[1]),
      .a       (x[PROD_A[i]]),
      .b       (x[PROD_B[i]]),
      .prod    (prod[i])
    );
  end

  fsq_column u_column (
    .clk  (clk),
    .en   (adv[2]),
    .prod (prod),
    .col  (col)
  );

  for (genvar k = 0; k < LIMB_N; k++) begin : g_split
    assign low1[k] = col[k][MASK_W-1:0];
    assign cy1[k]  = col[k][COL_W-1:MASK_W];
    assign low2[k] = r1[k][MASK_W-1:0];
    assign cy2[k]  = RED_W'(r1[k][RED_W-1:MASK_W]);
  end

  fsq_carry u_carry1 (
    .clk   (clk),
    .en    (adv[3]),
    .low   (low1),
    .carry (cy1),
    .res   (r1)
  );

  fsq_carry u_carry2 (
    .clk   (clk),
    .en    (adv[4]),
    .low   (low2),
    .carry (cy2),
    .res   (r2)
  );

  for (genvar k = 0; k < LIMB_N; k++) begin : g_pack
    assign m_axis_tdata[k*LIMB_W +: LIMB_W] = r2[k][LIMB_W-1:0];
  end
  assign m_axis_tdata[DATA_W-1:LIMB_N*LIMB_W] = '0;

endmodule

// ===== hdl/fsq_mul52.sv =====
// ----------------------------------------------------------------------------
// fsq_mul52
// Two-stage 52 x 52 multiplier: four registered 26 x 26 partial products,
// then a registered recombination into the full 104-bit product.
// ----------------------------------------------------------------------------
module fsq_mul52 import fsq_pkg::*; (
  input  logic  clk,
  input  logic  en_pp,
  input  logic  en_prod,
  input  limb_t a,
  input  limb_t b,
  output prod_t prod
);

  limb_t pp00;
  limb_t pp01;
  limb_t pp10;
  limb_t pp11;

  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp00 <= limb_t'(a[HALF_W-1:0]) * limb_t'(b[HALF_W-1:0]);
      pp01 <= limb_t'(a[HALF_W-1:0]) * limb_t'(b[LIMB_W-1:HALF_W]);
      pp10 <= limb_t'(a[LIMB_W-1:HALF_W]) * limb_t'(b[HALF_W-1:0]);
      pp11 <= limb_t'(a[LIMB_W-1:HALF_W]) * limb_t'(b[LIMB_W-1:HALF_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod <= {pp11, {LIMB_W{1'b0}}}
            + ((PROD_W'(pp01) + PROD_W'(pp10)) << HALF_W)
            + PROD_W'(pp00);
    end
  end

endmodule

// ===== hdl/fsq_column.sv =====
// ----------------------------------------------------------------------------
// fsq_column
// Scales the fifteen products by 1, 2, 19 or 38 and adds them into the five
// registered column sums.
// ----------------------------------------------------------------------------
module fsq_column import fsq_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  prod_t prod [PROD_N],
  output col_t  col  [LIMB_N]
);

  // Constant scaling by shifts and adds; 19 = 16 + 2 + 1, 38 = 32 + 4 + 2.
  function automatic col_t scale_prod(input prod_t p, input scale_t code);
    col_t w;
    w = COL_W'(p);
    case (code)
      SCALE_1:  return w;
      SCALE_2:  return w << 1;
      SCALE_19: return (w << 4) + (w << 1) + w;
      SCALE_38: return (w << 5) + (w << 2) + (w << 1);
      default:  return w;
    endcase
  endfunction

  for (genvar k = 0; k < LIMB_N; k++) begin : g_col
    always_ff @(posedge clk) begin
      if (en) begin
        col[k] <= scale_prod(prod[3*k],   PROD_SCALE[3*k])
                + scale_prod(prod[3*k+1], PROD_SCALE[3*k+1])
                + scale_prod(prod[3*k+2], PROD_SCALE[3*k+2]);
      end
    end
  end

endmodule

// ===== hdl/fsq_carry.sv =====
// ----------------------------------------------------------------------------
// fsq_carry
// One registered carry pass: each limb keeps its low 51 bits and takes the
// carry from the limb below; the top carry comes back into limb 0 times 19.
// ----------------------------------------------------------------------------
module fsq_carry import fsq_pkg::*; (
  input  logic clk,
  input  logic en,
  input  low_t low   [LIMB_N],
  input  red_t carry [LIMB_N],
  output red_t res   [LIMB_N]
);

  red_t wrap;

  // All sums here stay below 2^60, so the 61-bit arithmetic is exact.
  assign wrap = (carry[LIMB_N-1] << 4) + (carry[LIMB_N-1] << 1) + carry[LIMB_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      res[0] <= RED_W'(low[0]) + wrap;
    end
  end

  for (genvar k = 1; k < LIMB_N; k++) begin : g_limb
    always_ff @(posedge clk) begin
      if (en) begin
        res[k] <= RED_W'(low[k]) + carry[k-1];
      end
    end
  end

endmodule

// ===== hdl/fsq_checker.sv =====
// ----------------------------------------------------------------------------
// fsq_checker
// Port-level checks on the field squaring unit, bound to the top level.
// ----------------------------------------------------------------------------
module fsq_checker import fsq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata
);

  // Reset leaves no beat behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result beat valid straight after reset");

  // An output beat that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed or vanished");

  // With room at the output the whole pipeline can move, so input is taken.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled although the output stage was free");

  // After the second pass limb 0 exceeds 2^51 by less than 19 * 93.
  a_limb0_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[51] |-> m_axis_tdata[50:11] == '0)
    else $error("limb 0 of the result not carried down");

  // The upper limbs take a carry below 2^9 on top of 51 bits.
  a_limb1_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[103] |-> m_axis_tdata[102:61] == '0)
    else $error("limb 1 of the result not carried down");

endmodule

bind field_square_p25519_unit fsq_checker u_fsq_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the p25519 field squaring pipeline.
// ----------------------------------------------------------------------------
// Operands are five 52-bit limbs. They are offered on the input stream with
// random gaps, and squares are taken from the output stream with random
// stalls. Each accepted operand is squared by a behavioural model that uses
// exact wide arithmetic and the same two carry passes as the unit. The result
// is queued, and each square that leaves the unit is compared limb by limb
// with the oldest queued entry. One long receiver hold-off fills the pipeline
// so that the unit has to stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb import fsq_pkg::*; ();

  localparam int          IDLE_PCT   = 21;
  localparam int          RANDOM_N   = 1550;
  localparam int          HOLD_LEN   = 60;
  localparam int          HOLD_AT    = 300;
  localparam int          STEADY_LO  = 700;
  localparam int          STEADY_HI  = 1000;
  localparam int          STALL_MAX  = 500;
  localparam logic [63:0] LOW51      = (64'd1 << MASK_W) - 64'd1;
  localparam limb_t       LIMB_MAX   = {LIMB_W{1'b1}};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // in_limb0, in_limb1, .. in_limb4, pad
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // sq_limb0, sq_limb1, .. sq_limb4, pad

  int accepted_in = 0;
  bit steady = 1'b0;
  int stall_cycles = 0;

  // --------------------------------------------------------------------------
  class square_scoreboard;
    logic [DATA_W-1:0] expected_q[$];
    int errors = 0;

    static function logic [127:0] prod128(input logic [63:0] a, input logic [63:0] b);
      return {64'd0, a} * {64'd0, b};
    endfunction

    // Carry out of each limb goes to the next one up; the top carry wraps
    // round to limb 0 times 19, since 2^255 is 19 modulo p.
    static function void carry_pass(ref logic [63:0] r[LIMB_N], input logic [63:0] c[LIMB_N]);
      r[0] = (r[0] & LOW51) + c[4] * 64'd19;
      for (int i = 1; i < LIMB_N; i++) begin
        r[i] = (r[i] & LOW51) + c[i-1];
      end
    endfunction

    static function logic [DATA_W-1:0] square_p25519(input logic [DATA_W-1:0] operand);
      logic [63:0]       x[LIMB_N];
      logic [127:0]      col[LIMB_N];
      logic [63:0]       r[LIMB_N];
      logic [63:0]       c[LIMB_N];
      logic [DATA_W-1:0] sq;
      for (int i = 0; i < LIMB_N; i++) begin
        x[i] = 64'(operand[i*LIMB_W +: LIMB_W]);
      end
      col[0] = prod128(x[0], x[0]) + prod128(x[1] * 64'd38, x[4])
             + prod128(x[2] * 64'd38, x[3]);
      col[1] = prod128(x[0] * 64'd2, x[1]) + prod128(x[2] * 64'd38, x[4])
             + prod128(x[3] * 64'd19, x[3]);
      col[2] = prod128(x[0] * 64'd2, x[2]) + prod128(x[1], x[1])
             + prod128(x[3] * 64'd38, x[4]);
      col[3] = prod128(x[0] * 64'd2, x[3]) + prod128(x[1] * 64'd2, x[2])
             + prod128(x[4] * 64'd19, x[4]);
      col[4] = prod128(x[0] * 64'd2, x[4]) + prod128(x[1] * 64'd2, x[3])
             + prod128(x[2], x[2]);
      for (int i = 0; i < LIMB_N; i++) begin
        r[i] = col[i][63:0];
        c[i] = col[i][114:51];
      end
      carry_pass(r, c);
      for (int i = 0; i < LIMB_N; i++) begin
        c[i] = r[i] >> MASK_W;
      end
      carry_pass(r, c);
      sq = '0;
      for (int i = 0; i < LIMB_N; i++) begin
        sq[i*LIMB_W +: LIMB_W] = r[i][LIMB_W-1:0];
      end
      return sq;
    endfunction

    function void note_operand(input logic [DATA_W-1:0] operand);
      expected_q.push_back(square_p25519(operand));
    endfunction

    function void check_square(input logic [DATA_W-1:0] actual);
      logic [DATA_W-1:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: square beat with none expected, got %h", $time, actual);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < LIMB_N; i++) begin
        if (actual[i*LIMB_W +: LIMB_W] !== want[i*LIMB_W +: LIMB_W]) begin
          $display("%0t: sq_limb%0d expected %h, actual %h", $time, i,
                   want[i*LIMB_W +: LIMB_W], actual[i*LIMB_W +: LIMB_W]);
          errors++;
        end
      end
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction
  endclass
  // --------------------------------------------------------------------------

  square_scoreboard sb;

  field_square_p25519_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] pack_limbs(input limb_t l0, input limb_t l1,
                                                   input limb_t l2, input limb_t l3,
                                                   input limb_t l4);
    return {{(DATA_W - LIMB_N*LIMB_W){1'b0}}, l4, l3, l2, l1, l0};
  endfunction

  // Mixture of full-range, near-maximum, small and sparse limbs.
  function automatic limb_t random_limb();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LIMB_MAX;
      2: return LIMB_MAX ^ limb_t'($urandom_range(0, 255));
      3: return limb_t'($urandom_range(0, 1000));
      4: return limb_t'(1) << $urandom_range(0, LIMB_W-1);
      5: return limb_t'(raw[MASK_W-1:0]);
      default: return raw[LIMB_W-1:0];
    endcase
  endfunction

  task automatic send_operand(input logic [DATA_W-1:0] operand);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= operand;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_operand(operand);
    accepted_in++;
    steady = (accepted_in >= STEADY_LO) && (accepted_in < STEADY_HI);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_directed();
    limb_t lo51;
    lo51 = limb_t'(LOW51);
    send_operand(pack_limbs('0, '0, '0, '0, '0));
    send_operand(pack_limbs(limb_t'(1), '0, '0, '0, '0));
    send_operand(pack_limbs(LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX));
    send_operand(pack_limbs(lo51, lo51, lo51, lo51, lo51));
    // The prime itself and its neighbours.
    send_operand(pack_limbs(lo51 - limb_t'(18), lo51, lo51, lo51, lo51));
    send_operand(pack_limbs(lo51 - limb_t'(17), lo51, lo51, lo51, lo51));
    send_operand(pack_limbs(lo51 - limb_t'(19), lo51, lo51, lo51, lo51));
    send_operand(pack_limbs(lo51 + limb_t'(1), lo51 + limb_t'(1), lo51 + limb_t'(1),
                            lo51 + limb_t'(1), lo51 + limb_t'(1)));
    for (int i = 0; i < LIMB_N; i++) begin
      logic [DATA_W-1:0] one_limb;
      one_limb = '0;
      one_limb[i*LIMB_W +: LIMB_W] = LIMB_MAX;
      send_operand(one_limb);
    end
    send_operand(pack_limbs(LIMB_MAX, '0, LIMB_MAX, '0, LIMB_MAX));
    send_operand(pack_limbs('0, LIMB_MAX, '0, LIMB_MAX, '0));
    send_operand(pack_limbs({26{2'b10}}, {26{2'b01}}, {26{2'b10}}, {26{2'b01}},
                            {26{2'b10}}));
    send_operand(pack_limbs({26{2'b01}}, {26{2'b10}}, {26{2'b01}}, {26{2'b10}},
                            {26{2'b01}}));
    send_operand(pack_limbs('0, '0, '0, '0, limb_t'(1) << (LIMB_W-1)));
    send_operand(pack_limbs(limb_t'(2), '0, '0, '0, '0));
    send_operand(pack_limbs(LIMB_MAX, LIMB_MAX, '0, '0, '0));
    send_operand(pack_limbs('0, '0, '0, LIMB_MAX, LIMB_MAX));
  endtask

  // Receiver: random stalls, one long hold-off to back the pipeline up.
  initial begin
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && accepted_in >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_square(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_MAX);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    for (int n = 0; n < RANDOM_N; n++) begin
      send_operand(pack_limbs(random_limb(), random_limb(), random_limb(),
                              random_limb(), random_limb()));
    end
    s_axis_tvalid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fsq_pkg.sv
hdl/fsq_mul52.sv
hdl/fsq_column.sv
hdl/fsq_carry.sv
hdl/field_square_p25519_unit.sv
hdl/fsq_checker.sv
tb/tb.sv
